// ===== hw/rtl/button_click_long_press_detector_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Button click / long-press detector assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_LONG_PRESS_DETECTOR_UNIT_MACROS_SVH
`define BUTTON_CLICK_LONG_PRESS_DETECTOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define BCLP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bclp assertion failed");

// Next-cycle implication.
`define BCLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bclp assertion failed");

`endif

// ===== hw/rtl/bclp_pkg.sv =====
// ----------------------------------------------------------------------------
// Button click / long-press detector package
// Beat types, configuration types, register indexes and state codes.
// ----------------------------------------------------------------------------
package bclp_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_ID  = 4'd3;

    localparam logic [15:0] DEBOUNCE_RST   = 16'd20;
    localparam logic [15:0] LONG_PRESS_RST = 16'd650;
    localparam logic [15:0] CLICK_RST      = 16'd260;
    localparam logic [7:0]  BUTTON_ID_RST  = 8'd0;

    localparam logic [2:0] ST_IDLE          = 3'd0;
    localparam logic [2:0] ST_PRESSED       = 3'd1;
    localparam logic [2:0] ST_RELEASED      = 3'd2;
    localparam logic [2:0] ST_LONG_PRESSED  = 3'd3;
    localparam logic [2:0] ST_LONG_RELEASED = 3'd4;
    localparam logic [2:0] ST_CLICKED       = 3'd5;

    typedef struct packed {
        logic        pin_level;
        logic [31:0] now_ms;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  button_state;
        logic        state_changed;
        logic [7:0]  changed_identifier;
        logic        is_pressed;
        logic [31:0] hold_ms;
    } t_out_beat;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] long_press_ms;
        logic [15:0] click_ms;
        logic [7:0]  button_identifier;
    } t_cfg;

endpackage

// ===== hw/rtl/button_click_long_press_detector_unit.sv =====
// ----------------------------------------------------------------------------
// Button click / long-press detector
// Debounces polls of an active-low button and classifies presses as
// clicks, presses, releases and long presses.
// ----------------------------------------------------------------------------
// Each input beat is one poll of the pin with its millisecond timestamp and
// yields exactly one result beat: it passes through the input register and
// then the result register, with the debounce check and state update between
// them. The block sustains one poll per cycle while the output is not
// stalled. Configuration writes are taken at once and must only be
// issued while no poll is in flight.
module button_click_long_press_detector_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  bclp_pkg::t_in_beat               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output bclp_pkg::t_out_beat              o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bclp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bclp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bclp_pkg::*;

    `include "button_click_long_press_detector_unit_macros.svh"

    t_cfg      cfg;
    t_in_beat  r_in;
    logic      r_in_valid;
    t_out_beat r_out;
    logic      r_out_valid;
    t_out_beat result;
    logic      adv;
    logic      in_take;

    assign o_cfg_ready = 1'b1;

    bclp_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    bclp_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (adv),
        .i_beat   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (adv) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `BCLP_ASSERT_NEXT(a_step_fills_out, i_clk, i_rst_n, adv, r_out_valid)
    `BCLP_ASSERT_NEXT(a_held_poll_kept, i_clk, i_rst_n, o_in_stall, r_in_valid)
    `BCLP_ASSERT_NOW(a_no_event_no_id, i_clk, i_rst_n,
        o_out_valid && !o_out_data.state_changed, o_out_data.changed_identifier == 8'd0)
    `BCLP_ASSERT_NOW(a_state_code_legal, i_clk, i_rst_n,
        o_out_valid, o_out_data.button_state <= ST_CLICKED)

endmodule

// ===== hw/rtl/bclp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Button detector configuration registers
// Holds the debounce, long-press and click times and the button identifier.
// ----------------------------------------------------------------------------
module bclp_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_en,
    input  logic [bclp_pkg::CFG_IDX_W-1:0]   i_wr_index,
    input  logic [bclp_pkg::CFG_DATA_W-1:0]  i_wr_data,
    output bclp_pkg::t_cfg                   o_cfg
);
    import bclp_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms       <= DEBOUNCE_RST;
            r_cfg.long_press_ms     <= LONG_PRESS_RST;
            r_cfg.click_ms          <= CLICK_RST;
            r_cfg.button_identifier <= BUTTON_ID_RST;
        end else if (i_wr_en) begin
            case (i_wr_index)
                CFG_DEBOUNCE:   r_cfg.debounce_ms       <= i_wr_data;
                CFG_LONG_PRESS: r_cfg.long_press_ms     <= i_wr_data;
                CFG_CLICK:      r_cfg.click_ms          <= i_wr_data;
                CFG_BUTTON_ID:  r_cfg.button_identifier <= i_wr_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/bclp_fsm.sv =====
// ----------------------------------------------------------------------------
// Button detector debounce and state machine
// Holds the debounce and press state and forms the result beat of one poll.
// ----------------------------------------------------------------------------
module bclp_fsm (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  bclp_pkg::t_in_beat  i_beat,
    input  bclp_pkg::t_cfg      i_cfg,
    output bclp_pkg::t_out_beat o_result
);
    import bclp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE          = ST_IDLE,
        S_PRESSED       = ST_PRESSED,
        S_RELEASED      = ST_RELEASED,
        S_LONG_PRESSED  = ST_LONG_PRESSED,
        S_LONG_RELEASED = ST_LONG_RELEASED,
        S_CLICKED       = ST_CLICKED
    } t_fsm_state;

    t_fsm_state  r_state;
    t_fsm_state  n_state;
    t_fsm_state  r_reported;
    logic        r_last_level;
    logic [31:0] r_last_change;
    logic [31:0] r_press_start;
    logic [31:0] n_press_start;
    logic [31:0] r_elapsed;
    logic [31:0] n_elapsed;

    logic        pressed;
    logic        level_chg;
    logic        advance;
    logic        changed;
    logic [31:0] since_change;
    logic [31:0] hold_now;

    assign pressed      = ~i_beat.pin_level;
    assign level_chg    = pressed != r_last_level;
    assign since_change = i_beat.now_ms - r_last_change;
    assign hold_now     = i_beat.now_ms - r_press_start;
    assign advance      = !level_chg && (since_change > {16'd0, i_cfg.debounce_ms});

    always_comb begin
        n_state       = r_state;
        n_press_start = r_press_start;
        n_elapsed     = r_elapsed;
        if (advance) begin
            case (r_state)
                S_IDLE: begin
                    if (pressed) begin
                        n_state       = S_PRESSED;
                        n_press_start = i_beat.now_ms;
                        n_elapsed     = 32'd0;
                    end
                end
                S_PRESSED: begin
                    if (pressed) begin
                        n_elapsed = hold_now;
                        if (hold_now > {16'd0, i_cfg.long_press_ms}) begin
                            n_state = S_LONG_PRESSED;
                        end
                    end else if (hold_now < {16'd0, i_cfg.click_ms}) begin
                        n_state = S_CLICKED;
                    end else begin
                        n_state = S_RELEASED;
                    end
                end
                S_RELEASED, S_LONG_RELEASED: begin
                    if (pressed) begin
                        n_state       = S_PRESSED;
                        n_press_start = i_beat.now_ms;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
                S_LONG_PRESSED: begin
                    if (!pressed) begin
                        n_state = S_LONG_RELEASED;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    assign changed = advance && (n_state != r_reported);

    always_comb begin
        o_result.button_state       = n_state;
        o_result.state_changed      = changed;
        o_result.changed_identifier = changed ? i_cfg.button_identifier : 8'd0;
        o_result.is_pressed         = pressed;
        o_result.hold_ms            = n_elapsed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_reported    <= S_IDLE;
            r_last_level  <= 1'b0;
            r_last_change <= 32'd0;
            r_press_start <= 32'd0;
            r_elapsed     <= 32'd0;
        end else if (i_step) begin
            r_state       <= n_state;
            r_press_start <= n_press_start;
            r_elapsed     <= n_elapsed;
            if (changed) begin
                r_reported <= n_state;
            end
            if (level_chg) begin
                r_last_level  <= pressed;
                r_last_change <= i_beat.now_ms;
            end
        end
    end

endmodule
